FILE: sv/hfa_pkg.sv
// ----------------------------------------------------------------------------
// hfa_pkg
// Shared types and constants of the FU-A fragmenter.
// ----------------------------------------------------------------------------
package hfa_pkg;

   localparam logic [12:0] MAX_PAYLOAD_RESET = 13'd1400;
   localparam logic [12:0] MIN_PAYLOAD       = 13'd3;
   localparam logic [7:0]  NRI_MASK          = 8'hE0;
   localparam logic [7:0]  TYPE_MASK         = 8'h1F;
   localparam logic [4:0]  FU_A_TYPE         = 5'd28;
   localparam logic [7:0]  FU_START_BIT      = 8'h80;
   localparam logic [7:0]  FU_END_BIT        = 8'h40;

   // One classified input item: either a single byte result, or an FU
   // indicator, an FU header and a byte.
   typedef struct packed {
      logic       three;
      logic [7:0] indicator;
      logic [7:0] fu_header;
      logic [7:0] data;
      logic       packet_first;
      logic       packet_last;
      logic       unit_last;
   } hfa_desc_type;

endpackage

FILE: sv/hfa_front.sv
// ----------------------------------------------------------------------------
// hfa_front
// Tracks the position within the NAL unit and classifies each byte.
// ----------------------------------------------------------------------------
module hfa_front
   import hfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_value,
   input  logic [15:0]        unit_length,
   input  logic               csr_write_enable,
   input  logic [12:0]        csr_write_data,
   output logic               desc_valid,
   output hfa_desc_type       desc
);

   logic [12:0] max_payload_ff, max_payload_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] held_ff, held_in;
   logic        frag_ff, frag_in;
   logic [7:0]  ind_ff, ind_in;
   logic [4:0]  type_ff, type_in;
   logic [12:0] bip_ff, bip_in;

   logic        is_head;
   logic [15:0] len_eff;
   logic [12:0] eff_payload;
   logic [12:0] cap;
   logic [15:0] cur_len;
   logic        cur_frag;
   logic [7:0]  cur_ind;
   logic [4:0]  cur_type;
   logic [12:0] cur_bip;
   logic        last;
   logic [12:0] bip_inc;
   logic        closes;
   logic [7:0]  fu_header;

   always_comb begin
      is_head     = (pos_ff == 16'd0);
      len_eff     = (unit_length == 16'd0) ? 16'd1 : unit_length;
      eff_payload = (max_payload_ff < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_ff;
      cap         = eff_payload - 13'd2;
      cur_len     = is_head ? len_eff : held_ff;
      cur_frag    = is_head ? (len_eff > {3'd0, eff_payload}) : frag_ff;
      cur_ind     = is_head ? ((byte_value & NRI_MASK) | {3'd0, FU_A_TYPE}) : ind_ff;
      cur_type    = is_head ? byte_value[4:0] : type_ff;
      cur_bip     = is_head ? 13'd0 : bip_ff;
      last        = ({1'b0, pos_ff} + 17'd1) >= {1'b0, cur_len};
      bip_inc     = cur_bip + 13'd1;
      closes      = last || (bip_inc >= cap);

      if (pos_ff == 16'd1) begin
         fu_header = FU_START_BIT | {3'd0, cur_type};
      end else if (({1'b0, pos_ff} + {4'd0, cap}) >= {1'b0, cur_len}) begin
         fu_header = FU_END_BIT | {3'd0, cur_type};
      end else begin
         fu_header = {3'd0, cur_type};
      end

      desc.indicator = cur_ind;
      desc.fu_header = fu_header;
      desc.data      = byte_value;
      desc.unit_last = last;
      if (!cur_frag) begin
         desc.three        = 1'b0;
         desc.packet_first = is_head;
         desc.packet_last  = last;
      end else begin
         desc.three        = (cur_bip == 13'd0);
         desc.packet_first = 1'b0;
         desc.packet_last  = closes;
      end
      // the header byte of a split unit is held back
      desc_valid = accept && !(cur_frag && is_head);

      max_payload_in = csr_write_enable ? csr_write_data : max_payload_ff;
      pos_in  = pos_ff;
      held_in = held_ff;
      frag_in = frag_ff;
      ind_in  = ind_ff;
      type_in = type_ff;
      bip_in  = bip_ff;
      if (accept) begin
         held_in = cur_len;
         ind_in  = cur_ind;
         type_in = cur_type;
         if (last) begin
            pos_in  = 16'd0;
            frag_in = 1'b0;
            bip_in  = 13'd0;
         end else begin
            pos_in  = pos_ff + 16'd1;
            frag_in = cur_frag;
            if (!cur_frag || is_head || closes) begin
               bip_in = 13'd0;
            end else begin
               bip_in = bip_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         pos_ff         <= 16'd0;
         held_ff        <= 16'd0;
         frag_ff        <= 1'b0;
         ind_ff         <= 8'd0;
         type_ff        <= 5'd0;
         bip_ff         <= 13'd0;
      end else begin
         max_payload_ff <= max_payload_in;
         pos_ff         <= pos_in;
         held_ff        <= held_in;
         frag_ff        <= frag_in;
         ind_ff         <= ind_in;
         type_ff        <= type_in;
         bip_ff         <= bip_in;
      end
   end

endmodule

FILE: sv/hfa_queue.sv
// ----------------------------------------------------------------------------
// hfa_queue
// Small register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hfa_queue
   import hfa_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hfa_desc_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output hfa_desc_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   hfa_desc_type  slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full    = (count_ff == DEPTH_CNT);
      empty   = (count_ff == '0);
      head    = slot_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = do_push ? ((wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1)) : wr_ff;
      rd_in   = do_pop ? ((rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1)) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/hfa_back.sv
// ----------------------------------------------------------------------------
// hfa_back
// Expands a classified item into result items, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module hfa_back
   import hfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_empty,
   input  hfa_desc_type head,
   output logic         head_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_packet_first,
   output logic         rsp_packet_last,
   output logic         rsp_unit_last,
   output logic         rsp_run_last
);

   localparam logic [1:0] PH_INDICATOR = 2'd0;
   localparam logic [1:0] PH_HEADER    = 2'd1;
   localparam logic [1:0] PH_DATA      = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       pf_ff, pf_in, pl_ff, pl_in, ul_ff, ul_in, rl_ff, rl_in;
   logic       load;
   logic       final_sub;

   always_comb begin
      load      = !head_empty && (!valid_ff || rsp_pop);
      final_sub = !head.three || (phase_ff == PH_DATA);
      head_pop  = load && final_sub;

      byte_in = byte_ff;
      pf_in   = pf_ff;
      pl_in   = pl_ff;
      ul_in   = ul_ff;
      rl_in   = rl_ff;
      if (load) begin
         if (final_sub) begin
            byte_in = head.data;
            pf_in   = head.packet_first;
            pl_in   = head.packet_last;
            ul_in   = head.unit_last;
            rl_in   = 1'b1;
         end else begin
            byte_in = (phase_ff == PH_INDICATOR) ? head.indicator : head.fu_header;
            pf_in   = (phase_ff == PH_INDICATOR);
            pl_in   = 1'b0;
            ul_in   = 1'b0;
            rl_in   = 1'b0;
         end
      end

      valid_in = load || (valid_ff && !rsp_pop);

      phase_in = phase_ff;
      if (load) begin
         case (phase_ff)
            PH_INDICATOR: phase_in = head.three ? PH_HEADER : PH_INDICATOR;
            PH_HEADER:    phase_in = PH_DATA;
            default:      phase_in = PH_INDICATOR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INDICATOR;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pf_ff   <= pf_in;
      pl_ff   <= pl_in;
      ul_ff   <= ul_in;
      rl_ff   <= rl_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_packet_first = pf_ff;
   assign rsp_packet_last  = pl_ff;
   assign rsp_unit_last    = ul_ff;
   assign rsp_run_last     = rl_ff;

endmodule

FILE: sv/h264_fu_a_fragmenter.sv
// ----------------------------------------------------------------------------
// h264_fu_a_fragmenter
// Payload-side H.264 RTP packetiser (FU-A fragmentation, mode 1).
// ----------------------------------------------------------------------------
// NAL unit bytes come in header byte first, with the unit length sampled on
// that first byte. A unit that fits in max_payload bytes passes through as one
// packet; a longer one has its header held back and is cut into FU-A packets,
// each opened by an FU indicator and FU header item. Input rate is one item
// per cycle while the queue has room: the front end classifies each byte
// combinationally and pushes it into a QUEUE_DEPTH-entry queue. The back end
// drains it at one result item per cycle while the receiver pops, so the byte
// opening an FU packet costs three output items and back-pressures the input
// once the queue fills; otherwise the block streams at one byte per cycle.
// The user must write max_payload through csr_write_enable / csr_write_data
// only while idle; the block does not enforce it. Values below 3 act as 3.
// ----------------------------------------------------------------------------
module h264_fu_a_fragmenter
   import hfa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_unit_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_first,
   output logic        rsp_packet_last,
   output logic        rsp_unit_last,
   output logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data
);

   logic         accept;
   logic         desc_valid;
   hfa_desc_type desc;
   logic         q_empty;
   logic         q_pop;
   hfa_desc_type q_head;

   // an item is taken whenever the queue has a free slot
   assign accept = req_push && !req_full;

   hfa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .byte_value       (req_byte_value),
      .unit_length      (req_unit_length),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .desc_valid       (desc_valid),
      .desc             (desc)
   );

   hfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_valid),
      .push_data (desc),
      .pop       (q_pop),
      .full      (req_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   hfa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_empty       (q_empty),
      .head             (q_head),
      .head_pop         (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_first (rsp_packet_first),
      .rsp_packet_last  (rsp_packet_last),
      .rsp_unit_last    (rsp_unit_last),
      .rsp_run_last     (rsp_run_last)
   );

   // queue cannot claim full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(req_full && q_empty))
      else $error("queue full and empty together");

   // indicator and FU header are followed at once by the rest of their run
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_run_last) |=> !rsp_empty)
      else $error("gap inside an FU packet opening");

   // end of unit always closes the packet and the run
   a_unit_closes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unit_last) |-> (rsp_packet_last && rsp_run_last))
      else $error("unit end without packet end");

   // an FU lead-in item never closes a packet
   a_lead_in_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_run_last) |-> !rsp_packet_last)
      else $error("FU lead-in item marked as packet end");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FU-A fragmenter.
// ----------------------------------------------------------------------------
// A directed table goes first. It covers single-byte and zero-length units,
// pass-through units and split units at the smallest payload. It also covers
// payload limits below the minimum and above 4096, and a limit change part
// way through a split unit. Random NAL units follow, under several payload
// limits and four idling phases. Every result item is checked field by field
// against an in-bench model of the packetiser, or the table for PASS rows.
// ----------------------------------------------------------------------------
module tb_top
   import hfa_pkg::*;
();

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int QUIET_CYCLES = 16;    // queue depth plus pipeline, with margin
   localparam int SUB_ITEMS    = 42;    // min random items per payload setting

   // how a stimulus row is checked: DATA rows by the model, PASS rows with a
   // result typed in the table, HELD rows with none, CSR rows write max_payload
   typedef enum {ROW_DATA, ROW_PASS, ROW_HELD, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       packet_first;
      logic       packet_last;
      logic       unit_last;
      logic       run_last;
   } fu_byte_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   value;
      logic [15:0]  arg;     // unit length, or the new limit on CSR rows
      logic [3:0]   flags;   // first, last, unit end, run end of a PASS row
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_byte_value;
   logic [15:0] req_unit_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_first;
   logic        rsp_packet_last;
   logic        rsp_unit_last;
   logic        rsp_run_last;
   logic        csr_write_enable;
   logic [12:0] csr_write_data;

   // packetiser state, mirrored
   logic [12:0] payload_limit;
   logic [15:0] nal_pos;
   logic [15:0] nal_len;
   logic        split_unit;
   logic [7:0]  fu_indicator;
   logic [4:0]  nal_type;
   logic [12:0] frag_fill;

   fu_byte_type  packet_bytes_q[$];
   stim_row_type rows[$];
   int           mismatches;
   int           idle_pct;
   int           stall_pct;

   h264_fu_a_fragmenter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_byte_value   (req_byte_value),
      .req_unit_length  (req_unit_length),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_first (rsp_packet_first),
      .rsp_packet_last  (rsp_packet_last),
      .rsp_unit_last    (rsp_unit_last),
      .rsp_run_last     (rsp_run_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL h264_fu_a_fragmenter");
      $finish;
   end

   // Packetise one accepted byte into the outgoing byte queue. A header byte
   // latches length, split decision, FU indicator and NAL type. A split unit
   // drops its header; each FU packet opens with indicator and FU header.
   // Packet size and the end bit follow the limit in force now.
   function automatic void packetise_byte(input logic [7:0] b, input logic [15:0] ulen);
      int         eff;
      int         cap;
      int         pos;
      logic       last;
      logic       closes;
      logic [7:0] fu_hdr;
      eff = (payload_limit < MIN_PAYLOAD) ? int'(MIN_PAYLOAD) : int'(payload_limit);
      cap = eff - 2;
      pos = int'(nal_pos);
      if (pos == 0) begin
         nal_len      = (ulen == 16'd0) ? 16'd1 : ulen;
         split_unit   = int'(nal_len) > eff;
         fu_indicator = (b & NRI_MASK) | {3'b000, FU_A_TYPE};
         nal_type     = b[4:0] & TYPE_MASK[4:0];
         frag_fill    = '0;
      end
      last = (pos + 1 >= int'(nal_len));
      if (!split_unit) begin
         packet_bytes_q.push_back({b, pos == 0, last, last, 1'b1});
      end else if (pos != 0) begin
         if (frag_fill == 0) begin
            if (pos == 1)
               fu_hdr = FU_START_BIT | {3'b000, nal_type};
            else if (pos + cap >= int'(nal_len))
               fu_hdr = FU_END_BIT | {3'b000, nal_type};
            else
               fu_hdr = {3'b000, nal_type};
            packet_bytes_q.push_back({fu_indicator, 1'b1, 1'b0, 1'b0, 1'b0});
            packet_bytes_q.push_back({fu_hdr, 1'b0, 1'b0, 1'b0, 1'b0});
         end
         frag_fill = frag_fill + 13'd1;
         closes    = last || (int'(frag_fill) >= cap);
         packet_bytes_q.push_back({b, 1'b0, closes, last, 1'b1});
         if (closes)
            frag_fill = '0;
      end
      if (last) begin
         nal_pos    = '0;
         split_unit = 1'b0;
         frag_fill  = '0;
      end else begin
         nal_pos = 16'(pos + 1);
      end
   endfunction

   function automatic stim_row_type mk_row(input row_kind_type kind,
                                           input logic [7:0] value,
                                           input logic [15:0] arg,
                                           input logic [3:0] flags);
      stim_row_type r;
      r.kind  = kind;
      r.value = value;
      r.arg   = arg;
      r.flags = flags;
      return r;
   endfunction

   // Offer one item, with a random gap in front, and hold it until taken.
   // Payload lines carry junk during the gap.
   task automatic send_item(input logic [7:0] b, input logic [15:0] ulen,
                            input row_kind_type kind, input logic [3:0] flags);
      int held;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_push        <= 1'b0;
         req_byte_value  <= 8'($urandom);
         req_unit_length <= 16'($urandom);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_byte_value  <= b;
      req_unit_length <= ulen;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      held = packet_bytes_q.size();
      packetise_byte(b, ulen);
      if (kind == ROW_PASS || kind == ROW_HELD) begin
         // table gives the answer; the model only keeps its state in step
         while (packet_bytes_q.size() > held)
            void'(packet_bytes_q.pop_back());
         if (kind == ROW_PASS)
            packet_bytes_q.push_back({b, flags});
      end
   endtask

   // Stop sending and wait for every outstanding item, then let a held
   // header clear the pipeline as well.
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (packet_bytes_q.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_payload_limit(input logic [12:0] limit);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      payload_limit = limit;
   endtask

   // receiver: pop at random, stall rate set per phase
   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_results
      fu_byte_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (packet_bytes_q.size() == 0) begin
            $error("unexpected item: out_byte %02h", rsp_out_byte);
            mismatches++;
         end else begin
            want = packet_bytes_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_packet_first !== want.packet_first) begin
               $error("packet_first: expected %0b, got %0b", want.packet_first,
                      rsp_packet_first);
               mismatches++;
            end
            if (rsp_packet_last !== want.packet_last) begin
               $error("packet_last: expected %0b, got %0b", want.packet_last,
                      rsp_packet_last);
               mismatches++;
            end
            if (rsp_unit_last !== want.unit_last) begin
               $error("unit_last: expected %0b, got %0b", want.unit_last, rsp_unit_last);
               mismatches++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int          eff;
      int          lmax;
      int          ulen;
      int          sent;
      int          pick;
      logic [12:0] limit;
      bit          paused;

      reset            = 1'b1;
      req_push         = 1'b0;
      req_byte_value   = '0;
      req_unit_length  = '0;
      rsp_pop          = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      mismatches       = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      paused           = 1'b0;

      payload_limit = MAX_PAYLOAD_RESET;
      nal_pos       = '0;
      nal_len       = '0;
      split_unit    = 1'b0;
      fu_indicator  = '0;
      nal_type      = '0;
      frag_fill     = '0;

      // flags column: packet_first, packet_last, unit_last, run_last
      // one-byte unit, every bit set, at the reset limit
      rows.push_back(mk_row(ROW_PASS, 8'hFF, 16'd1,     4'b1111));
      // zero length counts as one byte
      rows.push_back(mk_row(ROW_PASS, 8'h00, 16'd0,     4'b1111));
      // three-byte pass-through; length ignored past the header
      rows.push_back(mk_row(ROW_PASS, 8'h65, 16'd3,     4'b1001));
      rows.push_back(mk_row(ROW_PASS, 8'hAA, 16'hFFFF,  4'b0001));
      rows.push_back(mk_row(ROW_PASS, 8'h55, 16'h0000,  4'b0111));
      // smallest limit: one unit byte per FU packet, start / middle / end
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'd3,     4'b0000));
      rows.push_back(mk_row(ROW_HELD, 8'hE5, 16'd4,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h11, 16'hFFFF,  4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h22, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h33, 16'h8000,  4'b0000));
      // limit of zero acts as three; a three-byte unit still fits
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_PASS, 8'h7F, 16'd3,     4'b1001));
      rows.push_back(mk_row(ROW_PASS, 8'h80, 16'd1,     4'b0001));
      rows.push_back(mk_row(ROW_PASS, 8'h01, 16'd2,     4'b0111));
      // limit raised part way through a split unit: second packet is
      // sized by the new limit and already carries the end bit
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'd4,     4'b0000));
      rows.push_back(mk_row(ROW_HELD, 8'h61, 16'd7,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0A, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0B, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'd6,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0C, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0D, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0E, 16'd0,     4'b0000));
      rows.push_back(mk_row(ROW_DATA, 8'h0F, 16'd0,     4'b0000));
      // largest register value is used as written
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'h1FFF,  4'b0000));
      rows.push_back(mk_row(ROW_PASS, 8'h9C, 16'd2,     4'b1001));
      rows.push_back(mk_row(ROW_PASS, 8'h3E, 16'd9,     4'b0111));
      rows.push_back(mk_row(ROW_CSR,  8'h00, 16'd4096,  4'b0000));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR)
            write_payload_limit(rows[i].arg[12:0]);
         else
            send_item(rows[i].value, rows[i].arg, rows[i].kind, rows[i].flags);
      end

      // random units: free flow, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 33 : 0;
         stall_pct = (phase == 2) ? 84 : (phase == 3) ? 33 : 0;
         for (int sub = 0; sub < 2; sub++) begin
            pick = $urandom_range(99);
            if (pick < 60)
               limit = 13'($urandom_range(12, 3));
            else if (pick < 75)
               limit = 13'($urandom_range(2, 0));
            else if (pick < 90)
               limit = 13'($urandom_range(64, 13));
            else
               limit = 13'($urandom_range(8191, 4096));
            write_payload_limit(limit);
            eff  = (limit < MIN_PAYLOAD) ? int'(MIN_PAYLOAD) : int'(limit);
            lmax = (3 * eff > 60) ? 60 : 3 * eff;
            sent = 0;
            while (sent < SUB_ITEMS) begin
               // mostly units around the split threshold, a few zero-length
               ulen = ($urandom_range(99) < 5) ? 0 : $urandom_range(lmax, 1);
               send_item(8'($urandom), 16'(ulen), ROW_DATA, 4'b0000);
               sent++;
               for (int k = 1; k < ulen; k++) begin
                  send_item(8'($urandom), 16'($urandom), ROW_DATA, 4'b0000);
                  sent++;
               end
               // hold the sender once until the output side runs dry
               if (phase == 3 && !paused && sent >= SUB_ITEMS / 2) begin
                  drain_results();
                  paused = 1'b1;
               end
            end
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("PASS h264_fu_a_fragmenter");
      else
         $display("FAIL h264_fu_a_fragmenter");
      $finish;
   end

endmodule
